>>> sv/tks_pkg.sv
// Shared constants, codes and types of the top-k sum multiset block.
package tks_pkg;

	localparam int CAPACITY = 64;
	localparam int VAL_W = 32;
	localparam int CNT_W = 7;
	localparam int SUM_W = 38;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int GRP_BITS = 3;
	localparam int GRP_SIZE = 1 << GRP_BITS;
	localparam int NGRP = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
	localparam int HI_W = IDX_W - GRP_BITS;
	localparam int RC_W = $clog2(CAPACITY + 2);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_ERASE = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_MISSING = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SELECT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LARGEST_MODE = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_PK1,
		ST_PK2,
		ST_UPD,
		ST_RCL
	} state_t;

	typedef struct packed {
		logic cmp;
		logic ins;
		logic era;
		logic signed [VAL_W-1:0] val;
	} cell_ctl_t;

endpackage

>>> sv/top_k_sum_multiset.sv
// Top level of the top-k sum multiset: control, running sum and the sorted cell chain.
// An accepted item passes through the compare, two-stage cell selection and shift steps of the
// chain before its result is registered; the next item is accepted only once the previous one has
// committed, and the update step waits while the result register is full and the output is stalled.
// A write to select_count or largest_mode starts a recomputation of the sum over the cells.
// Reset clears the count, the sum and both registers; stored values are left as they are.
module top_k_sum_multiset import tks_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   command,
	input  logic signed [VAL_W-1:0]      value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [SUM_W-1:0]      selected_sum,
	output logic [CNT_W-1:0]             element_count,
	output logic [1:0]                   status,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	state_t state_q, state_d;

	logic [CNT_W-1:0] k_q, cnt_q;
	logic mode_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [1:0] cmd_q;
	logic signed [VAL_W-1:0] val_q;
	logic [IDX_W-1:0] vidx_q, fidx_q;
	logic [RC_W-1:0] rcnt_q;
	logic rv_s1, rv_s2;
	logic out_valid_q;
	logic signed [SUM_W-1:0] out_sum_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic [1:0] out_status_q;

	cell_ctl_t ctl;
	logic cmp_en;
	logic signed [VAL_W-1:0] cell_val [CAPACITY];
	logic [CAPACITY-1:0] cell_le, cell_lt, cell_eq, fvec;
	logic signed [VAL_W-1:0] pick_val;
	logic pick_flag, found;
	logic [IDX_W-1:0] pick_vidx;

	logic in_take, cfg_take, cfg_hit, commit, out_take;
	logic is_ins, is_era, full, ins_ok, era_ok, win;
	logic [CNT_W-1:0] fidx_d, vidx_d;
	logic signed [SUM_W-1:0] vext, pext, add_a, add_b, new_sum;
	logic [CNT_W-1:0] new_cnt;
	logic [1:0] new_status;
	logic issue, rsel;
	logic [CNT_W:0] rk;

	assign cfg_take = cfg_valid && cfg_ready;
	assign cfg_hit = (cfg_index == REG_SELECT_COUNT) || (cfg_index == REG_LARGEST_MODE);
	assign in_take = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		cfg_ready = 1'b0;
		commit = 1'b0;
		cmp_en = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cfg_ready = 1'b1;
				in_stall = cfg_valid;
				if (cfg_valid && cfg_hit) begin
					state_d = ST_RCL;
				end else if (in_valid && !cfg_valid) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				cmp_en = 1'b1;
				state_d = ST_PK1;
			end
			ST_PK1: state_d = ST_PK2;
			ST_PK2: state_d = ST_UPD;
			ST_UPD: begin
				commit = !out_valid_q || !out_stall;
				if (commit) begin
					state_d = ST_IDLE;
				end
			end
			ST_RCL: begin
				if (rcnt_q == RC_W'(CAPACITY + 1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign is_ins = cmd_q == CMD_INSERT;
	assign is_era = cmd_q == CMD_ERASE;
	assign full = cnt_q == CNT_W'(CAPACITY);
	assign ins_ok = is_ins && !full;
	assign era_ok = is_era && found;
	assign win = (k_q != '0) && ((k_q > cnt_q) || (mode_q ? pick_flag : !pick_flag));

	assign ctl = '{cmp: cmp_en, ins: commit && ins_ok, era: commit && era_ok, val: val_q};

	always_comb begin
		if (!mode_q) begin
			fidx_d = k_q - CNT_W'(1);
			vidx_d = (command == CMD_ERASE) ? k_q : k_q - CNT_W'(1);
		end else begin
			fidx_d = cnt_q - k_q;
			vidx_d = (command == CMD_ERASE) ? cnt_q - k_q - CNT_W'(1) : cnt_q - k_q;
		end
	end

	assign vext = {{(SUM_W - VAL_W){val_q[VAL_W-1]}}, val_q};
	assign pext = {{(SUM_W - VAL_W){pick_val[VAL_W-1]}}, pick_val};

	always_comb begin
		add_a = '0;
		add_b = '0;
		if (ins_ok && win) begin
			add_a = vext;
			if (k_q <= cnt_q) begin
				add_b = -pext;
			end
		end else if (era_ok && win) begin
			add_a = -vext;
			if (k_q < cnt_q) begin
				add_b = pext;
			end
		end
		new_sum = sum_q + add_a + add_b;
		new_cnt = cnt_q;
		if (ins_ok) begin
			new_cnt = cnt_q + CNT_W'(1);
		end else if (era_ok) begin
			new_cnt = cnt_q - CNT_W'(1);
		end
		priority if (is_ins && full) begin
			new_status = STATUS_FULL;
		end else if (is_era && !found) begin
			new_status = STATUS_MISSING;
		end else begin
			new_status = STATUS_OK;
		end
	end

	assign issue = (state_q == ST_RCL) && (rcnt_q < RC_W'(CAPACITY));
	assign rk = (CNT_W + 1)'(rcnt_q);
	assign rsel = (rk < {1'b0, cnt_q})
		&& (mode_q ? (rk + {1'b0, k_q} >= {1'b0, cnt_q}) : (rk < {1'b0, k_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			mode_q <= 1'b0;
			cnt_q <= '0;
			sum_q <= '0;
			rcnt_q <= '0;
			rv_s1 <= 1'b0;
			rv_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1 <= issue && rsel;
			rv_s2 <= rv_s1;
			if (cfg_take && cfg_hit) begin
				if (cfg_index == REG_SELECT_COUNT) begin
					k_q <= cfg_data;
				end else begin
					mode_q <= cfg_data[0];
				end
				sum_q <= '0;
				rcnt_q <= '0;
			end else if (state_q == ST_RCL) begin
				rcnt_q <= rcnt_q + RC_W'(1);
				if (rv_s2) begin
					sum_q <= sum_q + pext;
				end
			end else if (commit) begin
				sum_q <= new_sum;
				cnt_q <= new_cnt;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q <= command;
			val_q <= value;
			vidx_q <= vidx_d[IDX_W-1:0];
			fidx_q <= fidx_d[IDX_W-1:0];
		end
		if (commit) begin
			out_sum_q <= new_sum;
			out_cnt_q <= new_cnt;
			out_status_q <= new_status;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] pv, nv;
		logic ple;
		if (i == 0) begin : g_first
			assign pv = val_q;
			assign ple = 1'b1;
		end else begin : g_mid
			assign pv = cell_val[i-1];
			assign ple = cell_le[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign nv = '0;
		end else begin : g_next
			assign nv = cell_val[i+1];
		end
		tks_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.pos      (IDX_W'(i)),
			.held     (cnt_q),
			.prev_val (pv),
			.prev_le  (ple),
			.next_val (nv),
			.val      (cell_val[i]),
			.le       (cell_le[i]),
			.lt       (cell_lt[i]),
			.eq       (cell_eq[i])
		);
	end

	assign fvec = (is_era && !mode_q) ? cell_lt : cell_le;
	assign pick_vidx = (state_q == ST_RCL) ? rcnt_q[IDX_W-1:0] : vidx_q;

	tks_pick u_pick (
		.clk       (clk),
		.vals      (cell_val),
		.flags     (fvec),
		.eqs       (cell_eq),
		.vidx      (pick_vidx),
		.fidx      (fidx_q),
		.pick_val  (pick_val),
		.pick_flag (pick_flag),
		.found     (found)
	);

	assign out_valid = out_valid_q;
	assign selected_sum = out_sum_q;
	assign element_count = out_cnt_q;
	assign status = out_status_q;

endmodule

>>> sv/tks_cell.sv
// One cell of the sorted chain: holds one value, compares it and shifts with its neighbors.
module tks_cell import tks_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cell_ctl_t               ctl,
	input  logic [IDX_W-1:0]        pos,
	input  logic [CNT_W-1:0]        held,
	input  logic signed [VAL_W-1:0] prev_val,
	input  logic                    prev_le,
	input  logic signed [VAL_W-1:0] next_val,
	output logic signed [VAL_W-1:0] val,
	output logic                    le,
	output logic                    lt,
	output logic                    eq
);

	logic signed [VAL_W-1:0] val_q;
	logic le_q, lt_q, eq_q;
	logic occ;

	assign occ = CNT_W'(pos) < held;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			le_q <= 1'b0;
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.cmp) begin
			le_q <= occ && (val_q <= ctl.val);
			lt_q <= occ && (val_q < ctl.val);
			eq_q <= occ && (val_q == ctl.val);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins && !le_q) begin
			val_q <= prev_le ? ctl.val : prev_val;
		end else if (ctl.era && !lt_q) begin
			val_q <= next_val;
		end
	end

	assign val = val_q;
	assign le = le_q;
	assign lt = lt_q;
	assign eq = eq_q;

endmodule

>>> sv/tks_pick.sv
// Two-stage registered selection of one cell value and one cell flag, and the match reduction.
module tks_pick import tks_pkg::*; (
	input  logic                    clk,
	input  logic signed [VAL_W-1:0] vals [CAPACITY],
	input  logic [CAPACITY-1:0]     flags,
	input  logic [CAPACITY-1:0]     eqs,
	input  logic [IDX_W-1:0]        vidx,
	input  logic [IDX_W-1:0]        fidx,
	output logic signed [VAL_W-1:0] pick_val,
	output logic                    pick_flag,
	output logic                    found
);

	logic [VAL_W-1:0] grp_val [NGRP];
	logic [NGRP-1:0]  grp_flag, grp_eq;
	logic [VAL_W-1:0] grp_val_s1 [NGRP];
	logic [NGRP-1:0]  grp_flag_s1, grp_eq_s1;
	logic [HI_W-1:0]  vhi_s1, fhi_s1;
	logic [VAL_W-1:0] sel_val;
	logic             sel_flag;
	logic signed [VAL_W-1:0] val_s2;
	logic             flag_s2, found_s2;

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_val[g] = '0;
			grp_flag[g] = 1'b0;
			grp_eq[g] = 1'b0;
			for (int j = 0; j < GRP_SIZE; j++) begin
				if (g * GRP_SIZE + j < CAPACITY) begin
					if (vidx[GRP_BITS-1:0] == GRP_BITS'(j)) begin
						grp_val[g] = grp_val[g] | vals[g * GRP_SIZE + j];
					end
					if (fidx[GRP_BITS-1:0] == GRP_BITS'(j)) begin
						grp_flag[g] = grp_flag[g] | flags[g * GRP_SIZE + j];
					end
					grp_eq[g] = grp_eq[g] | eqs[g * GRP_SIZE + j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_val_s1 <= grp_val;
		grp_flag_s1 <= grp_flag;
		grp_eq_s1 <= grp_eq;
		vhi_s1 <= vidx[IDX_W-1:GRP_BITS];
		fhi_s1 <= fidx[IDX_W-1:GRP_BITS];
	end

	always_comb begin
		sel_val = '0;
		sel_flag = 1'b0;
		for (int g = 0; g < NGRP; g++) begin
			if (vhi_s1 == HI_W'(g)) begin
				sel_val = sel_val | grp_val_s1[g];
			end
			if (fhi_s1 == HI_W'(g)) begin
				sel_flag = sel_flag | grp_flag_s1[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		val_s2 <= sel_val;
		flag_s2 <= sel_flag;
		found_s2 <= |grp_eq_s1;
	end

	assign pick_val = val_s2;
	assign pick_flag = flag_s2;
	assign found = found_s2;

endmodule
